@@ sv/susi_pkg.sv @@
// susi_pkg: shared constants and types of the sorted unique set insert unit
// no dependencies; used by the interfaces, the compare unit and the top level
`default_nettype none

package susi_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int FUNC_W = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_READ      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  value_out;
        logic        [POS_W-1:0]  position;
        logic        [CNT_W-1:0]  count;
        logic                     last;
    } t_res;

endpackage

`default_nettype wire

@@ sv/susi_in_if.sv @@
// susi_in_if: request channel of the sorted unique set insert unit
// depends on susi_pkg for field widths
`default_nettype none

interface susi_in_if;
    logic                            valid;
    logic                            ready;
    logic [susi_pkg::FUNC_W-1:0]     func;
    logic signed [susi_pkg::VAL_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

@@ sv/susi_out_if.sv @@
// susi_out_if: result channel of the sorted unique set insert unit
// depends on susi_pkg for field widths
`default_nettype none

interface susi_out_if;
    logic                              valid;
    logic                              ready;
    logic [susi_pkg::STAT_W-1:0]       status;
    logic signed [susi_pkg::VAL_W-1:0] value_out;
    logic [susi_pkg::POS_W-1:0]        position;
    logic [susi_pkg::CNT_W-1:0]        count;
    logic                              last;

    modport source (output valid, output status, output value_out, output position,
                    output count, output last, input ready);
    modport sink   (input valid, input status, input value_out, input position,
                    input count, input last, output ready);
endinterface

`default_nettype wire

@@ sv/susi_cmp.sv @@
// susi_cmp: two's complement compare of a table entry against the key
// depends on susi_pkg for widths and the compare result struct
`default_nettype none

module susi_cmp (
    input  wire logic signed [susi_pkg::VAL_W-1:0] i_entry,
    input  wire logic signed [susi_pkg::VAL_W-1:0] i_key,
    output susi_pkg::t_cmp                          o_res
);

    always_comb begin
        o_res.lt = (i_entry < i_key);
        o_res.eq = (i_entry == i_key);
    end

endmodule

`default_nettype wire

@@ sv/sorted_unique_set_insert_unit.sv @@
// sorted_unique_set_insert_unit: bounded ascending table of unique signed values
// depends on susi_pkg, susi_in_if, susi_out_if and susi_cmp
//
// usage:
//   i_in carries one request item (func, value); o_out carries result items
//   (status, value_out, position, count, last). both are valid/ready channels.
//   insert: the table is scanned upward from entry 0 with one compare a cycle
//   until the sorted position is found, then the entries at and above it move
//   up one a cycle, top first, and the new value is written in the freed slot.
//   duplicate and full inserts end after the scan with one result.
//   read-out: one result per cycle while the output is free, in ascending order,
//   last mark on the final one; an empty table gives a single empty-status result.
//   clear: empties the table and gives one cleared result.
//   the scan and move rates are set by the single compare unit and the one-read,
//   one-write table. i_in.ready is high only between items.
//   a finished result waits in the output register; while it waits with
//   o_out.ready low the read-out pauses and no further item finishes.
//   reset empties the table at once through its entry count; table contents
//   are not cleared.
`default_nettype none

module sorted_unique_set_insert_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    susi_in_if.sink     i_in,
    susi_out_if.source  o_out
);

    localparam int IDX_W = susi_pkg::IDX_W;
    localparam int CNT_W = susi_pkg::CNT_W;
    localparam int POS_W = susi_pkg::POS_W;
    localparam int VAL_W = susi_pkg::VAL_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRCH  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PLACE = 6'b001000,
        S_READ  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [VAL_W-1:0]  r_val, n_val;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [IDX_W-1:0]         r_pos, n_pos;
    susi_pkg::t_res           r_pend, n_pend;
    susi_pkg::t_res           r_out, n_out;
    logic                     r_ovalid, n_ovalid;

    logic signed [VAL_W-1:0]  r_mem [susi_pkg::CAPACITY];
    logic signed [VAL_W-1:0]  r_rdata;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [VAL_W-1:0]  mem_wdata;
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_raddr;

    susi_pkg::t_cmp           cmp_res;
    logic                     out_free;
    logic                     full;
    logic [CNT_W-1:0]         idx_cnt_nxt;

    susi_cmp u_cmp (
        .i_entry (r_rdata),
        .i_key   (r_val),
        .o_res   (cmp_res)
    );

    assign out_free    = !r_ovalid || o_out.ready;
    assign full        = (r_count == CNT_W'(susi_pkg::CAPACITY));
    assign idx_cnt_nxt = CNT_W'(r_idx) + CNT_W'(1);

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.status    = r_out.status;
    assign o_out.value_out = r_out.value_out;
    assign o_out.position  = r_out.position;
    assign o_out.count     = r_out.count;
    assign o_out.last      = r_out.last;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_val     = r_val;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_pend    = r_pend;
        n_out     = r_out;
        n_ovalid  = r_ovalid && !o_out.ready;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.func)
                        susi_pkg::FN_INSERT: begin
                            n_val = i_in.value;
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_PLACE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_state   = S_SRCH;
                            end
                        end
                        susi_pkg::FN_READ: begin
                            if (r_count == '0) begin
                                n_pend  = '{status: susi_pkg::ST_EMPTY, value_out: '0,
                                            position: '0, count: '0, last: 1'b1};
                                n_state = S_EMIT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_READ;
                            end
                        end
                        susi_pkg::FN_CLEAR: begin
                            n_count = '0;
                            n_pend  = '{status: susi_pkg::ST_CLEARED, value_out: '0,
                                        position: '0, count: '0, last: 1'b1};
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (cmp_res.eq) begin
                    n_pend  = '{status: susi_pkg::ST_DUPLICATE, value_out: '0,
                                position: POS_W'(r_idx), count: r_count, last: 1'b1};
                    n_state = S_EMIT;
                end else if (cmp_res.lt) begin
                    if (idx_cnt_nxt == r_count) begin
                        if (full) begin
                            n_pend  = '{status: susi_pkg::ST_FULL, value_out: '0,
                                        position: '0, count: r_count, last: 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            n_pos   = r_count[IDX_W-1:0];
                            n_state = S_PLACE;
                        end
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_idx + IDX_W'(1);
                        n_idx     = r_idx + IDX_W'(1);
                    end
                end else begin
                    if (full) begin
                        n_pend  = '{status: susi_pkg::ST_FULL, value_out: '0,
                                    position: '0, count: r_count, last: 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_pos     = r_idx;
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(r_count - CNT_W'(1));
                        n_idx     = IDX_W'(r_count - CNT_W'(1));
                        n_state   = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx + IDX_W'(1);
                mem_wdata = r_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - IDX_W'(1);
                    n_idx     = r_idx - IDX_W'(1);
                end
            end
            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
                n_count   = r_count + CNT_W'(1);
                n_pend    = '{status: susi_pkg::ST_INSERTED, value_out: r_val,
                              position: POS_W'(r_pos), count: r_count + CNT_W'(1),
                              last: 1'b1};
                n_state   = S_EMIT;
            end
            S_READ: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{status: susi_pkg::ST_READ, value_out: r_rdata,
                                 position: POS_W'(r_idx), count: r_count,
                                 last: (idx_cnt_nxt == r_count)};
                    if (idx_cnt_nxt == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_idx + IDX_W'(1);
                        n_idx     = r_idx + IDX_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_pend;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // sorted table, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(susi_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == susi_pkg::ST_READ) |->
        ((CNT_W'(o_out.position) + CNT_W'(1) == o_out.count) == o_out.last))
        else $error("read-out last mark does not match position");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != susi_pkg::ST_READ) |-> o_out.last)
        else $error("single result item without last mark");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.func == susi_pkg::FN_CLEAR) |=>
        (r_count == '0))
        else $error("clear did not empty the table");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the table by one");

endmodule

`default_nettype wire

@@ tb/sv/sorted_unique_set_insert_unit_tb.sv @@
// sorted_unique_set_insert_unit_tb: self-checking bench for the sorted unique set insert unit
// drives insert, read-out, clear and unused-function items, predicts every result and checks them in order
// depends on susi_pkg, susi_in_if, susi_out_if and sorted_unique_set_insert_unit
`timescale 1ns / 100ps

module sorted_unique_set_insert_unit_tb;
    import susi_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 600000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PULSE,
        RX_MOSTLY
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    susi_in_if  in_ch ();
    susi_out_if out_ch ();

    sorted_unique_set_insert_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // predicted copy of the set
    logic signed [VAL_W-1:0] model_set [CAPACITY];
    int                      model_count;
    t_res                    due_results [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int dup_drops      = 0;
    int full_drops     = 0;
    int readouts       = 0;
    int burst_left     = 0;
    int cycle_count    = 0;
    int rx_cycle       = 0;
    t_rx_mode rx_mode  = RX_OPEN;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_result(input t_status st, input logic signed [VAL_W-1:0] v,
                               input int pos, input int cnt, input logic lst);
        t_res r;
        r.status    = st;
        r.value_out = v;
        r.position  = POS_W'(pos);
        r.count     = CNT_W'(cnt);
        r.last      = lst;
        due_results.push_back(r);
    endtask

    task automatic set_apply(input logic [FUNC_W-1:0] fn, input logic signed [VAL_W-1:0] v);
        int pos;
        int n;
        n = model_count;
        case (fn)
            FN_INSERT: begin
                pos = 0;
                while (pos < n && model_set[pos] < v)
                    pos++;
                if (pos < n && model_set[pos] == v) begin
                    push_result(ST_DUPLICATE, '0, pos, n, 1'b1);
                    dup_drops++;
                end else if (n >= CAPACITY) begin
                    push_result(ST_FULL, '0, 0, n, 1'b1);
                    full_drops++;
                end else begin
                    for (int i = n; i > pos; i--)
                        model_set[i] = model_set[i-1];
                    model_set[pos] = v;
                    model_count    = n + 1;
                    push_result(ST_INSERTED, v, pos, n + 1, 1'b1);
                end
            end
            FN_READ: begin
                readouts++;
                if (n == 0)
                    push_result(ST_EMPTY, '0, 0, 0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        push_result(ST_READ, model_set[i], i, n, (i == n - 1));
            end
            FN_CLEAR: begin
                model_count = 0;
                push_result(ST_CLEARED, '0, 0, 0, 1'b1);
            end
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic signed [VAL_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_ch.func  <= fn;
        in_ch.value <= v;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        set_apply(fn, v);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (due_results.size() != 0);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return int'($urandom_range(0, 15)) - 8;
        if (sel < 50) begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh8000_0001;
                3: return 32'sh7fff_fffe;
                4: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_error($sformatf("result status %0d with nothing pending", out_ch.status));
            end else begin
                r = due_results.pop_front();
                if (out_ch.status !== r.status || out_ch.value_out !== r.value_out ||
                    out_ch.position !== r.position || out_ch.count !== r.count ||
                    out_ch.last !== r.last)
                    report_error($sformatf(
                        "got st %0d val %0d pos %0d cnt %0d last %0b, exp %0d %0d %0d %0d %0b",
                        out_ch.status, out_ch.value_out, out_ch.position, out_ch.count,
                        out_ch.last, r.status, r.value_out, r.position, r.count, r.last));
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0)
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_PULSE:  out_ch.ready <= (rx_cycle % 4 == 0);
            default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_basic_ops();
        send_item(FN_READ, 32'sh0);
        send_item(FN_CLEAR, -32'sd1);
        send_item(FN_UNUSED, -32'sd1);
        send_item(FN_INSERT, 32'sh0);
        send_item(FN_INSERT, 32'sh7fff_ffff);
        send_item(FN_INSERT, 32'sh8000_0000);
        send_item(FN_INSERT, -32'sd1);
        send_item(FN_INSERT, 32'sd1);
        send_item(FN_INSERT, 32'sh8000_0000);
        send_item(FN_INSERT, 32'sh7fff_ffff);
        send_item(FN_INSERT, 32'sh0);
        send_item(FN_READ, 32'sh5555_aaaa);
        send_item(FN_UNUSED, 32'sh0);
        send_item(FN_CLEAR, 32'sh0);
        send_item(FN_READ, 32'sh0);
        send_item(FN_INSERT, 32'sh7fff_ffff);
        send_item(FN_INSERT, 32'sh8000_0001);
        drain_results();
    endtask

    // even fill values plus both extremes, so an odd value other than the top extreme is always new
    task automatic test_full_table();
        send_item(FN_CLEAR, 32'sh0);
        send_item(FN_INSERT, 32'sh7fff_ffff);
        send_item(FN_INSERT, 32'sh8000_0000);
        while (model_count < CAPACITY)
            send_item(FN_INSERT, $urandom & 32'hffff_fffe);
        send_item(FN_INSERT, 32'sd1);
        send_item(FN_INSERT, 32'sh8000_0000);
        send_item(FN_INSERT, 32'sh7fff_ffff);
        send_item(FN_INSERT, model_set[CAPACITY/2]);
        send_item(FN_READ, 32'sh0);
        send_item(FN_INSERT, -32'sd3);
        send_item(FN_CLEAR, 32'sh0);
        drain_results();
    endtask

    task automatic test_random_mixed(input int num);
        int unsigned sel;
        for (int k = 0; k < num; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 82)
                send_item(FN_INSERT, pick_value());
            else if (sel < 94)
                send_item(FN_READ, $urandom);
            else if (sel < 97)
                send_item(FN_CLEAR, $urandom);
            else
                send_item(FN_UNUSED, $urandom);
            if (k == num / 2)
                drain_results();
        end
        drain_results();
    endtask

    task automatic test_random_refills(input int num);
        int stop_at;
        int fills;
        bit narrow;
        stop_at = items_sent + num;
        while (items_sent < stop_at) begin
            send_item(FN_CLEAR, $urandom);
            fills  = $urandom_range(4, CAPACITY + 6);
            narrow = $urandom_range(0, 1);
            for (int k = 0; k < fills; k++) begin
                if (narrow)
                    send_item(FN_INSERT, int'($urandom_range(0, 40)) - 20);
                else
                    send_item(FN_INSERT, $urandom);
                if ($urandom_range(0, 19) == 0)
                    send_item(FN_UNUSED, $urandom);
            end
            send_item(FN_READ, $urandom);
        end
        drain_results();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.func   = FN_INSERT;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_full_table();
        test_random_mixed(240);
        test_random_refills(160);

        in_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (due_results.size() != 0)
            report_error($sformatf("%0d results never arrived", due_results.size()));

        $display("sent %0d items (%0d read-outs), checked %0d results", items_sent, readouts,
                 results_seen);
        $display("saw %0d duplicate drops and %0d full-table drops", dup_drops, full_drops);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/susi_pkg.sv
sv/susi_in_if.sv
sv/susi_out_if.sv
sv/susi_cmp.sv
sv/sorted_unique_set_insert_unit.sv
tb/sv/sorted_unique_set_insert_unit_tb.sv
